>>> sv/mmbp_pkg.sv
// Shared types, codes and counter helpers for the multi-mode branch predictor.
// No dependencies; every other file of the block imports this package.
package mmbp_pkg;

   localparam int PC_W      = 32;
   localparam int WBITS_W   = 4;
   localparam int CFG_IDX_W = 2;
   localparam int CFG_DAT_W = 4;

   typedef enum logic [1:0] {
      MODE_STATIC     = 2'd0,
      MODE_GSHARE     = 2'd1,
      MODE_TOURNAMENT = 2'd2,
      MODE_HYBRID     = 2'd3
   } mode_type;

   typedef enum logic {
      CMD_PREDICT = 1'b0,
      CMD_TRAIN   = 1'b1
   } cmd_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_MODE       = 2'd0,
      REG_GHIST_BITS = 2'd1,
      REG_LHIST_BITS = 2'd2,
      REG_PC_BITS    = 2'd3
   } reg_idx_type;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_MIN     = 2'd0;
   localparam ctr_type CTR_WEAK_NT = 2'd1;
   localparam ctr_type CTR_MAX     = 2'd3;

   // Effective configuration after clamping of the width registers.
   typedef struct packed {
      mode_type             mode;
      logic [WBITS_W-1:0]   gbits;
      logic [WBITS_W-1:0]   lbits;
      logic [WBITS_W-1:0]   pbits;
   } cfg_type;

   function automatic ctr_type ctr_bump(ctr_type c, logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + 2'd1;
      end else begin
         if (c != CTR_MIN) r = c - 2'd1;
      end
      return r;
   endfunction

   function automatic logic ctr_taken(ctr_type c);
      return c[1];
   endfunction

endpackage

>>> sv/mmbp_req_if.sv
// Request channel: predict or train transaction with pc and outcome.
// Depends on mmbp_pkg.
interface mmbp_req_if;
   import mmbp_pkg::*;

   logic              valid;
   logic              ready;
   cmd_type           cmd;
   logic [PC_W-1:0]   pc;
   logic              outcome;

   modport source (output valid, output cmd, output pc, output outcome, input ready);
   modport sink   (input valid, input cmd, input pc, input outcome, output ready);
endinterface

>>> sv/mmbp_rsp_if.sv
// Response channel: predicted direction, one transaction per predict.
// Depends on mmbp_pkg.
interface mmbp_rsp_if;
   import mmbp_pkg::*;

   logic valid;
   logic ready;
   logic taken;

   modport source (output valid, output taken, input ready);
   modport sink   (input valid, input taken, output ready);
endinterface

>>> sv/mmbp_csr_if.sv
// Configuration write channel: register index and write data.
// Depends on mmbp_pkg.
interface mmbp_csr_if;
   import mmbp_pkg::*;

   logic                   valid;
   logic                   ready;
   reg_idx_type            index;
   logic [CFG_DAT_W-1:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> sv/multi_mode_branch_predictor_top.sv
// Multi-mode branch predictor (static taken, gshare, tournament, hybrid). One predict or
// train transaction is accepted per cycle; a predict's taken bit comes from the chained
// table reads (local history, then local counter), the update stage and the output
// register. Outside the clearing pass, acceptance stalls only while a result waits in the
// output register and the stage behind it holds another predict. After reset a clearing
// pass over max(2**MAX_GLOBAL_BITS, 2**MAX_LOCAL_BITS, 2**MAX_PC_INDEX_BITS) entries
// (8192 by default) initializes the tables while req ready is low; csr writes are taken.
// Depends on mmbp_pkg, mmbp_req_if, mmbp_rsp_if, mmbp_csr_if and mmbp_csr.
module multi_mode_branch_predictor_top #(
   parameter int MAX_GLOBAL_BITS   = 13,
   parameter int MAX_LOCAL_BITS    = 10,
   parameter int MAX_PC_INDEX_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   mmbp_req_if.sink    req_chan,
   mmbp_rsp_if.source  rsp_chan,
   mmbp_csr_if.sink    csr_chan
);
   import mmbp_pkg::*;

   localparam int GW   = MAX_GLOBAL_BITS;
   localparam int LW   = MAX_LOCAL_BITS;
   localparam int PW   = MAX_PC_INDEX_BITS;
   localparam int GTAB = 1 << GW;
   localparam int LTAB = 1 << LW;
   localparam int HTAB = 1 << PW;
   localparam int CLR_DEPTH = (GTAB > LTAB) ? ((GTAB > HTAB) ? GTAB : HTAB)
                                            : ((LTAB > HTAB) ? LTAB : HTAB);
   localparam int CLR_W = $clog2(CLR_DEPTH);

   cfg_type cfg;

   mmbp_csr #(
      .MAX_GLOBAL_BITS  (MAX_GLOBAL_BITS),
      .MAX_LOCAL_BITS   (MAX_LOCAL_BITS),
      .MAX_PC_INDEX_BITS(MAX_PC_INDEX_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_chan(csr_chan),
      .cfg     (cfg)
   );

   // Tables
   ctr_type        gc_mem [GTAB];
   ctr_type        ch_mem [GTAB];
   ctr_type        lc_mem [LTAB];
   logic [LW-1:0]  lh_mem [HTAB];

   logic [GW-1:0] gmask;
   logic [LW-1:0] lmask;
   logic [PW-1:0] pmask;
   logic          tour;

   logic             clr_busy_ff;
   logic [CLR_W-1:0] clr_cnt_ff;

   logic [GW-1:0] ghist_ff;
   logic [GW-1:0] ghist_in;
   logic [GW-1:0] ghist_cur;
   logic [GW-1:0] gsh_idx;
   logic [GW-1:0] g_idx;
   logic [PW-1:0] h_idx;
   logic          accept;
   logic          adv;

   // Stage 1
   logic          s1_vld_ff;
   cmd_type       s1_cmd_ff;
   logic          s1_outcome_ff;
   logic [GW-1:0] s1_ghist_ff;
   logic [GW-1:0] s1_gidx_ff;
   logic [PW-1:0] s1_hidx_ff;
   ctr_type       s1_gc_raw_ff, s1_gc_bv_ff;
   logic          s1_gc_byp_ff;
   ctr_type       s1_ch_raw_ff, s1_ch_bv_ff;
   logic          s1_ch_byp_ff;
   logic [LW-1:0] s1_lh_raw_ff, s1_lh_bv_ff;
   logic          s1_lh_byp_ff;
   ctr_type       s1_gc_eff;
   ctr_type       s1_ch_eff;
   logic [LW-1:0] s1_lh_eff;
   logic [LW-1:0] s1_lpat;

   // Stage 2
   logic          s2_vld_ff;
   cmd_type       s2_cmd_ff;
   logic          s2_outcome_ff;
   logic [GW-1:0] s2_ghist_ff;
   logic [GW-1:0] s2_gidx_ff;
   logic [PW-1:0] s2_hidx_ff;
   logic [LW-1:0] s2_lpat_ff;
   ctr_type       s2_gc_ff;
   ctr_type       s2_ch_ff;
   ctr_type       s2_lc_raw_ff, s2_lc_bv_ff;
   logic          s2_lc_byp_ff;
   ctr_type       s2_lc_eff;
   logic          s2_local_g;
   logic          s2_global_g;
   logic          s2_guess;

   logic last_local_ff;
   logic last_global_ff;
   logic out_vld_ff;
   logic out_taken_ff;

   // Update-stage writes
   logic          s2_wr;
   logic          gc_wr, ch_wr, lc_wr, lh_wr;
   ctr_type       gc_wdata, ch_wdata, lc_wdata;
   logic [LW-1:0] lh_new;

   // Memory write ports (update or clearing pass)
   logic          gc_we, ch_we, lc_we, lh_we;
   logic [GW-1:0] gc_wa, ch_wa;
   logic [LW-1:0] lc_wa;
   logic [PW-1:0] lh_wa;
   ctr_type       gc_wd, ch_wd, lc_wd;
   logic [LW-1:0] lh_wd;

   always_comb begin
      for (int i = 0; i < GW; i++) gmask[i] = (i < int'(cfg.gbits));
      for (int i = 0; i < LW; i++) lmask[i] = (i < int'(cfg.lbits));
      for (int i = 0; i < PW; i++) pmask[i] = (i < int'(cfg.pbits));
   end

   assign tour = (cfg.mode == MODE_TOURNAMENT) || (cfg.mode == MODE_HYBRID);

   // Accept side
   assign adv = !s2_vld_ff || (s2_cmd_ff == CMD_TRAIN) || !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv && !clr_busy_ff;
   assign accept = req_chan.valid && req_chan.ready;

   assign ghist_cur = ghist_ff & gmask;
   assign gsh_idx   = (req_chan.pc[GW-1:0] ^ ghist_cur) & gmask;
   assign g_idx     = ((cfg.mode == MODE_GSHARE) || (cfg.mode == MODE_HYBRID)) ? gsh_idx
                                                                               : ghist_cur;
   assign h_idx     = req_chan.pc[PW-1:0] & pmask;

   always_comb begin
      ghist_in = ghist_ff;
      if (accept && (req_chan.cmd == CMD_TRAIN) && (cfg.mode != MODE_STATIC)) begin
         ghist_in = ((ghist_cur << 1) & gmask) | GW'(req_chan.outcome);
      end
   end

   // Update stage
   assign s2_wr = adv && s2_vld_ff && (s2_cmd_ff == CMD_TRAIN) && (cfg.mode != MODE_STATIC);
   assign gc_wr = s2_wr;
   assign ch_wr = s2_wr && tour && (last_local_ff != last_global_ff);
   assign lc_wr = s2_wr && tour;
   assign lh_wr = s2_wr && tour;

   assign s2_lc_eff = s2_lc_byp_ff ? s2_lc_bv_ff : s2_lc_raw_ff;
   assign gc_wdata  = ctr_bump(s2_gc_ff, s2_outcome_ff);
   assign ch_wdata  = ctr_bump(s2_ch_ff, last_global_ff != s2_outcome_ff);
   assign lc_wdata  = ctr_bump(s2_lc_eff, s2_outcome_ff);
   assign lh_new    = ((s2_lpat_ff << 1) & lmask) | LW'(s2_outcome_ff);

   assign s2_local_g  = ctr_taken(s2_lc_eff);
   assign s2_global_g = ctr_taken(s2_gc_ff);

   always_comb begin
      case (cfg.mode)
         MODE_STATIC: s2_guess = 1'b1;
         MODE_GSHARE: s2_guess = s2_global_g;
         default:     s2_guess = ctr_taken(s2_ch_ff) ? s2_local_g : s2_global_g;
      endcase
   end

   // Stage 1 effective read data, with forwarding from the update stage
   assign s1_gc_eff = s1_gc_byp_ff ? s1_gc_bv_ff : s1_gc_raw_ff;
   assign s1_ch_eff = s1_ch_byp_ff ? s1_ch_bv_ff : s1_ch_raw_ff;
   assign s1_lh_eff = s1_lh_byp_ff ? s1_lh_bv_ff : s1_lh_raw_ff;
   assign s1_lpat   = ((lh_wr && (s2_hidx_ff == s1_hidx_ff)) ? lh_new : s1_lh_eff) & lmask;

   // Write port selection
   always_comb begin
      if (clr_busy_ff) begin
         gc_we = (int'(clr_cnt_ff) < GTAB);
         ch_we = (int'(clr_cnt_ff) < GTAB);
         lc_we = (int'(clr_cnt_ff) < LTAB);
         lh_we = (int'(clr_cnt_ff) < HTAB);
         gc_wa = clr_cnt_ff[GW-1:0];
         ch_wa = clr_cnt_ff[GW-1:0];
         lc_wa = clr_cnt_ff[LW-1:0];
         lh_wa = clr_cnt_ff[PW-1:0];
         gc_wd = CTR_WEAK_NT;
         ch_wd = CTR_WEAK_NT;
         lc_wd = CTR_WEAK_NT;
         lh_wd = '0;
      end else begin
         gc_we = gc_wr;
         ch_we = ch_wr;
         lc_we = lc_wr;
         lh_we = lh_wr;
         gc_wa = s2_gidx_ff;
         ch_wa = s2_ghist_ff;
         lc_wa = s2_lpat_ff;
         lh_wa = s2_hidx_ff;
         gc_wd = gc_wdata;
         ch_wd = ch_wdata;
         lc_wd = lc_wdata;
         lh_wd = lh_new;
      end
   end

   // Memories
   always_ff @(posedge clock) begin
      if (gc_we) gc_mem[gc_wa] <= gc_wd;
      if (adv) s1_gc_raw_ff <= gc_mem[g_idx];
   end

   always_ff @(posedge clock) begin
      if (ch_we) ch_mem[ch_wa] <= ch_wd;
      if (adv) s1_ch_raw_ff <= ch_mem[ghist_cur];
   end

   always_ff @(posedge clock) begin
      if (lh_we) lh_mem[lh_wa] <= lh_wd;
      if (adv) s1_lh_raw_ff <= lh_mem[h_idx];
   end

   always_ff @(posedge clock) begin
      if (lc_we) lc_mem[lc_wa] <= lc_wd;
      if (adv) s2_lc_raw_ff <= lc_mem[s1_lpat];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff    <= 1'b1;
         clr_cnt_ff     <= '0;
         ghist_ff       <= '0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
         last_local_ff  <= 1'b0;
         last_global_ff <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
            if (int'(clr_cnt_ff) == CLR_DEPTH - 1) clr_busy_ff <= 1'b0;
         end
         ghist_ff <= ghist_in;
         if (adv) begin
            s1_vld_ff <= accept;
            s2_vld_ff <= s1_vld_ff;
            if (s2_vld_ff && (s2_cmd_ff == CMD_PREDICT) && tour) begin
               last_local_ff  <= s2_local_g;
               last_global_ff <= s2_global_g;
            end
         end
         if (adv && s2_vld_ff && (s2_cmd_ff == CMD_PREDICT)) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff     <= req_chan.cmd;
         s1_outcome_ff <= req_chan.outcome;
         s1_ghist_ff   <= ghist_cur;
         s1_gidx_ff    <= g_idx;
         s1_hidx_ff    <= h_idx;
         s1_gc_byp_ff  <= gc_wr && (s2_gidx_ff == g_idx);
         s1_gc_bv_ff   <= gc_wdata;
         s1_ch_byp_ff  <= ch_wr && (s2_ghist_ff == ghist_cur);
         s1_ch_bv_ff   <= ch_wdata;
         s1_lh_byp_ff  <= lh_wr && (s2_hidx_ff == h_idx);
         s1_lh_bv_ff   <= lh_new;

         s2_cmd_ff     <= s1_cmd_ff;
         s2_outcome_ff <= s1_outcome_ff;
         s2_ghist_ff   <= s1_ghist_ff;
         s2_gidx_ff    <= s1_gidx_ff;
         s2_hidx_ff    <= s1_hidx_ff;
         s2_lpat_ff    <= s1_lpat;
         s2_gc_ff      <= (gc_wr && (s2_gidx_ff == s1_gidx_ff)) ? gc_wdata : s1_gc_eff;
         s2_ch_ff      <= (ch_wr && (s2_ghist_ff == s1_ghist_ff)) ? ch_wdata : s1_ch_eff;
         s2_lc_byp_ff  <= lc_wr && (s2_lpat_ff == s1_lpat);
         s2_lc_bv_ff   <= lc_wdata;
      end
      if (adv && s2_vld_ff && (s2_cmd_ff == CMD_PREDICT)) begin
         out_taken_ff <= s2_guess;
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.taken = out_taken_ff;

   // Checks
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_chan.ready)
      else $error("request accepted during table clearing");

   a_pipe_empty_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("pipeline busy during table clearing");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(s1_vld_ff) && $stable(s2_vld_ff)))
      else $error("pipeline moved while stalled");

   a_rsp_from_predict: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(s2_vld_ff && (s2_cmd_ff == CMD_PREDICT)))
      else $error("response raised without a predict transaction");

endmodule

>>> sv/mmbp_csr.sv
// Configuration registers of the predictor with width clamping.
// Depends on mmbp_pkg and mmbp_csr_if.
module mmbp_csr #(
   parameter int MAX_GLOBAL_BITS   = 13,
   parameter int MAX_LOCAL_BITS    = 10,
   parameter int MAX_PC_INDEX_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   mmbp_csr_if.sink          csr_chan,
   output mmbp_pkg::cfg_type cfg
);
   import mmbp_pkg::*;

   localparam int WBITS_MAX = (1 << WBITS_W) - 1;
   localparam int RST_G = (MAX_GLOBAL_BITS > WBITS_MAX) ? WBITS_MAX : MAX_GLOBAL_BITS;
   localparam int RST_L = (MAX_LOCAL_BITS > WBITS_MAX) ? WBITS_MAX : MAX_LOCAL_BITS;
   localparam int RST_P = (MAX_PC_INDEX_BITS > WBITS_MAX) ? WBITS_MAX : MAX_PC_INDEX_BITS;

   mode_type             mode_ff;
   logic [WBITS_W-1:0]   gbits_ff;
   logic [WBITS_W-1:0]   lbits_ff;
   logic [WBITS_W-1:0]   pbits_ff;

   function automatic logic [WBITS_W-1:0] clamp_bits(logic [WBITS_W-1:0] v, int max_bits);
      logic [WBITS_W-1:0] r;
      r = v;
      if (v == '0) r = WBITS_W'(1);
      else if (int'(v) > max_bits) r = WBITS_W'(max_bits);
      return r;
   endfunction

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_STATIC;
         gbits_ff <= WBITS_W'(RST_G);
         lbits_ff <= WBITS_W'(RST_L);
         pbits_ff <= WBITS_W'(RST_P);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_MODE:       mode_ff  <= mode_type'(csr_chan.wdata[1:0]);
            REG_GHIST_BITS: gbits_ff <= csr_chan.wdata;
            REG_LHIST_BITS: lbits_ff <= csr_chan.wdata;
            REG_PC_BITS:    pbits_ff <= csr_chan.wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.mode  = mode_ff;
      cfg.gbits = clamp_bits(gbits_ff, MAX_GLOBAL_BITS);
      cfg.lbits = clamp_bits(lbits_ff, MAX_LOCAL_BITS);
      cfg.pbits = clamp_bits(pbits_ff, MAX_PC_INDEX_BITS);
   end

endmodule
